@@ sv/csbp_pkg.sv @@
// Shared widths, codes, types and helpers of the CAN signal pack and unpack block.
package csbp_pkg;

    localparam int MAX_BYTES  = 64;
    localparam int ADDR_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int BYTE_W     = 8;
    localparam int RAW_W      = 64;
    localparam int WIN_BYTES  = 9;
    localparam int WIN_W      = WIN_BYTES * BYTE_W;
    localparam int CNT_W      = $clog2(WIN_BYTES + 1);
    localparam int SHAMT_W    = $clog2(WIN_W);
    localparam int START_W    = 9;
    localparam int LEN_W      = 6;
    localparam int FLEN_W     = 7;
    localparam int IDX_W      = 6;
    localparam int FIRST_W    = START_W - 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_READ    = 2'd1,
        OP_EXTRACT = 2'd2,
        OP_INSERT  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIG_START    = 3'd0,
        CFG_SIG_LEN      = 3'd1,
        CFG_MOTOROLA     = 3'd2,
        CFG_SIGN_EXT     = 3'd3,
        CFG_FRAME_LENGTH = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_RDWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [START_W-1:0] sig_start;
        logic [LEN_W-1:0]   sig_len;
        logic               motorola;
        logic               sign_ext;
        logic [FLEN_W-1:0]  frame_length;
    } t_sig_cfg;

    typedef struct packed {
        logic               fits;
        logic [FIRST_W-1:0] first_byte;
        logic [SHAMT_W-1:0] shamt;
        logic [RAW_W-1:0]   len_mask;
    } t_sig_geom;

    // Reverses the byte order of a window, so that the first frame byte sits on top.
    function automatic logic [WIN_W-1:0] swap_bytes(input logic [WIN_W-1:0] w);
        logic [WIN_W-1:0] r;
        for (int j = 0; j < WIN_BYTES; j++) begin
            r[j*BYTE_W +: BYTE_W] = w[(WIN_BYTES-1-j)*BYTE_W +: BYTE_W];
        end
        return r;
    endfunction

endpackage

@@ sv/csbp_in_if.sv @@
// Input item channel of the CAN signal pack and unpack block.
interface csbp_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        op;
    logic [csbp_pkg::IDX_W-1:0]        byte_index;
    logic [csbp_pkg::BYTE_W-1:0]       byte_value;
    logic signed [csbp_pkg::RAW_W-1:0] raw_in;

    modport source (output valid, op, byte_index, byte_value, raw_in, input ready);
    modport sink (input valid, op, byte_index, byte_value, raw_in, output ready);
endinterface

@@ sv/csbp_out_if.sv @@
// Result item channel of the CAN signal pack and unpack block.
interface csbp_out_if;
    logic                              valid;
    logic                              ready;
    logic                              ok;
    logic signed [csbp_pkg::RAW_W-1:0] raw_out;
    logic [csbp_pkg::BYTE_W-1:0]       byte_out;

    modport source (output valid, ok, raw_out, byte_out, input ready);
    modport sink (input valid, ok, raw_out, byte_out, output ready);
endinterface

@@ sv/csbp_cfg_if.sv @@
// Configuration write channel of the CAN signal pack and unpack block.
interface csbp_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [csbp_pkg::CFG_IDX_W-1:0]    index;
    logic [csbp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/can_signal_bit_pack_unpack.sv @@
// Top level of the CAN signal pack and unpack block: frame byte store and sequencer.
//
// Items arrive on i_in and each gives exactly one result on o_out; both channels transfer
// when valid and ready are high at a rising edge. Register writes arrive on i_cfg, which is
// always ready, and must only be issued while no item is outstanding.
// The frame sits in a byte RAM with a registered read port.
// A load goes straight to the output register, a read after its RAM access. Extract and
// insert first check the signal against the frame; a signal that fits then streams the
// nine bytes of the signal window through the single read port (insert writes each
// modified byte back once it has been read), and the output register is loaded last, from
// which the result transfers. The next item is accepted in the cycle after the previous
// result reaches the output register, so items are taken one at a time.
// Reset restores the register defaults and marks every stored byte empty; an empty byte
// reads as zero, so no clearing sweep is needed.
// When the receiver stalls, one result waits in the output register while the next item is
// accepted and processed; that item then holds in its final step until the register frees.
module can_signal_bit_pack_unpack (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csbp_in_if.sink    i_in,
    csbp_out_if.source o_out,
    csbp_cfg_if.sink   i_cfg
);

    localparam int IDX_CMP_W = csbp_pkg::IDX_W + 1;
    localparam int RUN_AW    = csbp_pkg::FIRST_W + 1;
    localparam int AW        = csbp_pkg::ADDR_W;
    localparam int BW        = csbp_pkg::BYTE_W;

    csbp_pkg::t_state    r_state;
    csbp_pkg::t_state    n_state;
    csbp_pkg::t_sig_cfg  r_cfg;
    csbp_pkg::t_sig_geom geom;
    csbp_pkg::t_op       in_op;
    csbp_pkg::t_op       r_op;

    logic [csbp_pkg::MAX_BYTES-1:0] r_valid;
    logic [csbp_pkg::CNT_W-1:0]     r_rd_cnt;
    logic                           r_pend;
    logic                           r_rd_keep;
    logic [AW-1:0]                  r_wr_addr;
    logic [csbp_pkg::RAW_W-1:0]     r_raw_in;
    logic                           r_ok;
    logic [BW-1:0]                  r_byte;
    logic [csbp_pkg::WIN_W-1:0]     r_win;
    logic [csbp_pkg::WIN_W-1:0]     r_dwin;
    logic [csbp_pkg::WIN_W-1:0]     r_mwin;
    logic                           r_out_valid;
    logic                           r_out_ok;
    logic [csbp_pkg::RAW_W-1:0]     r_out_raw;
    logic [BW-1:0]                  r_out_byte;

    logic                       in_fire;
    logic                       cfg_fire;
    logic                       idx_ok;
    logic                       out_load;
    logic                       rd_more;
    logic [RUN_AW-1:0]          run_addr;
    logic                       run_inr;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [BW-1:0]              ram_wdata;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic [BW-1:0]              ram_q;
    logic [BW-1:0]              rd_byte;
    logic [BW-1:0]              ins_byte;
    logic [csbp_pkg::RAW_W-1:0] ins_data;
    logic [csbp_pkg::WIN_W-1:0] ins_dsh;
    logic [csbp_pkg::WIN_W-1:0] ins_msh;
    logic [csbp_pkg::WIN_W-1:0] ext_stream;
    logic [csbp_pkg::WIN_W-1:0] ext_shift;
    logic [csbp_pkg::RAW_W-1:0] ext_raw;
    logic [csbp_pkg::RAW_W-1:0] ext_val;
    logic                       ext_neg;

    csbp_sig_check u_check (
        .i_cfg  (r_cfg),
        .o_geom (geom)
    );

    csbp_ram #(
        .WIDTH (BW),
        .DEPTH (csbp_pkg::MAX_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign in_op    = csbp_pkg::t_op'(i_in.op);
    assign in_fire  = i_in.valid && i_in.ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;
    assign idx_ok   = {1'b0, i_in.byte_index} < IDX_CMP_W'(csbp_pkg::MAX_BYTES);
    assign rd_more  = r_rd_cnt < csbp_pkg::CNT_W'(csbp_pkg::WIN_BYTES);
    assign run_addr = RUN_AW'(geom.first_byte) + RUN_AW'(r_rd_cnt);
    assign run_inr  = run_addr < RUN_AW'(csbp_pkg::MAX_BYTES);
    assign rd_byte  = r_rd_keep ? ram_q : '0;
    assign ins_byte = (rd_byte & ~r_mwin[BW-1:0]) | r_dwin[BW-1:0];

    always_comb begin
        ins_data   = r_raw_in & geom.len_mask;
        ins_dsh    = csbp_pkg::WIN_W'(ins_data) << geom.shamt;
        ins_msh    = csbp_pkg::WIN_W'(geom.len_mask) << geom.shamt;
        ext_stream = r_cfg.motorola ? csbp_pkg::swap_bytes(r_win) : r_win;
        ext_shift  = ext_stream >> geom.shamt;
        ext_raw    = ext_shift[csbp_pkg::RAW_W-1:0] & geom.len_mask;
        // A signal of 63 bits stays unextended.
        ext_neg    = r_cfg.sign_ext &&
                     (r_cfg.sig_len != csbp_pkg::LEN_W'(csbp_pkg::RAW_W - 1)) &&
                     ext_raw[r_cfg.sig_len - csbp_pkg::LEN_W'(1)];
        ext_val    = ext_neg ? (ext_raw | ~geom.len_mask) : ext_raw;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            csbp_pkg::S_IDLE: begin
                if (in_fire) begin
                    case (in_op)
                        csbp_pkg::OP_LOAD: n_state = csbp_pkg::S_DONE;
                        csbp_pkg::OP_READ: begin
                            n_state = idx_ok ? csbp_pkg::S_RDWAIT : csbp_pkg::S_DONE;
                        end
                        default:           n_state = csbp_pkg::S_CHECK;
                    endcase
                end
            end
            csbp_pkg::S_CHECK: begin
                n_state = geom.fits ? csbp_pkg::S_RUN : csbp_pkg::S_DONE;
            end
            csbp_pkg::S_RUN: begin
                if (r_pend && !rd_more) begin
                    n_state = csbp_pkg::S_DONE;
                end
            end
            csbp_pkg::S_RDWAIT: begin
                n_state = csbp_pkg::S_DONE;
            end
            csbp_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = csbp_pkg::S_IDLE;
                end
            end
            default: n_state = csbp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        i_cfg.ready = 1'b1;
        out_load    = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        case (r_state)
            csbp_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid && idx_ok) begin
                    if (in_op == csbp_pkg::OP_LOAD) begin
                        ram_we    = 1'b1;
                        ram_waddr = i_in.byte_index[AW-1:0];
                        ram_wdata = i_in.byte_value;
                    end
                    if (in_op == csbp_pkg::OP_READ) begin
                        ram_re    = 1'b1;
                        ram_raddr = i_in.byte_index[AW-1:0];
                    end
                end
            end
            csbp_pkg::S_RUN: begin
                if (rd_more && run_inr) begin
                    ram_re    = 1'b1;
                    ram_raddr = run_addr[AW-1:0];
                end
                if (r_pend && (r_op == csbp_pkg::OP_INSERT) && (r_mwin[BW-1:0] != '0)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wr_addr;
                    ram_wdata = ins_byte;
                end
            end
            csbp_pkg::S_DONE: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state            <= csbp_pkg::S_IDLE;
            r_valid            <= '0;
            r_rd_cnt           <= '0;
            r_pend             <= 1'b0;
            r_rd_keep          <= 1'b0;
            r_out_valid        <= 1'b0;
            r_cfg.sig_start    <= '0;
            r_cfg.sig_len      <= csbp_pkg::LEN_W'(8);
            r_cfg.motorola     <= 1'b0;
            r_cfg.sign_ext     <= 1'b0;
            r_cfg.frame_length <= csbp_pkg::FLEN_W'(8);
        end else begin
            r_state   <= n_state;
            r_rd_keep <= ram_re && r_valid[ram_raddr];
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (r_state == csbp_pkg::S_CHECK) begin
                r_rd_cnt <= '0;
            end else if (r_state == csbp_pkg::S_RUN && rd_more) begin
                r_rd_cnt <= r_rd_cnt + csbp_pkg::CNT_W'(1);
            end
            r_pend <= (r_state == csbp_pkg::S_RUN) && rd_more;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                case (csbp_pkg::t_cfg_idx'(i_cfg.index))
                    csbp_pkg::CFG_SIG_START:
                        r_cfg.sig_start <= i_cfg.data[csbp_pkg::START_W-1:0];
                    csbp_pkg::CFG_SIG_LEN:
                        r_cfg.sig_len <= i_cfg.data[csbp_pkg::LEN_W-1:0];
                    csbp_pkg::CFG_MOTOROLA:
                        r_cfg.motorola <= i_cfg.data[0];
                    csbp_pkg::CFG_SIGN_EXT:
                        r_cfg.sign_ext <= i_cfg.data[0];
                    csbp_pkg::CFG_FRAME_LENGTH:
                        r_cfg.frame_length <= i_cfg.data[csbp_pkg::FLEN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            csbp_pkg::S_IDLE: begin
                if (in_fire) begin
                    r_op     <= in_op;
                    r_raw_in <= i_in.raw_in;
                    r_byte   <= '0;
                    r_ok     <= ((in_op == csbp_pkg::OP_LOAD) || (in_op == csbp_pkg::OP_READ)) &&
                                idx_ok;
                end
            end
            csbp_pkg::S_CHECK: begin
                r_ok   <= geom.fits;
                r_dwin <= r_cfg.motorola ? csbp_pkg::swap_bytes(ins_dsh) : ins_dsh;
                r_mwin <= r_cfg.motorola ? csbp_pkg::swap_bytes(ins_msh) : ins_msh;
            end
            csbp_pkg::S_RUN: begin
                if (rd_more) begin
                    r_wr_addr <= run_addr[AW-1:0];
                end
                if (r_pend) begin
                    r_win  <= {rd_byte, r_win[csbp_pkg::WIN_W-1:BW]};
                    r_dwin <= r_dwin >> BW;
                    r_mwin <= r_mwin >> BW;
                end
            end
            csbp_pkg::S_RDWAIT: begin
                r_byte <= rd_byte;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_ok   <= r_ok;
            r_out_byte <= r_byte;
            r_out_raw  <= ((r_op == csbp_pkg::OP_EXTRACT) && r_ok) ? ext_val : '0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.ok       = r_out_ok;
    assign o_out.raw_out  = r_out_raw;
    assign o_out.byte_out = r_out_byte;

    a_ram_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == csbp_pkg::S_IDLE) && (in_op == csbp_pkg::OP_LOAD)) ||
                   ((r_state == csbp_pkg::S_RUN) && (r_op == csbp_pkg::OP_INSERT)))
        else $error("frame store written outside a load or an insert");

    a_run_only_when_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csbp_pkg::S_RUN) |-> geom.fits)
        else $error("byte sweep running for a signal that does not fit");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == csbp_pkg::S_RUN) && r_pend && !rd_more) |=> (r_state == csbp_pkg::S_DONE))
        else $error("byte sweep did not finish after the last window byte");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == csbp_pkg::S_DONE))
        else $error("result register loaded outside the final step");

endmodule

@@ sv/csbp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module csbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/csbp_sig_check.sv @@
// Signal placement check: fit against the frame, first byte, window shift and length mask.
module csbp_sig_check (
    input  csbp_pkg::t_sig_cfg  i_cfg,
    output csbp_pkg::t_sig_geom o_geom
);

    localparam int FB_W   = csbp_pkg::FLEN_W + 3;
    localparam int TAIL_W = csbp_pkg::LEN_W + 1;
    localparam int LAST_W = csbp_pkg::FIRST_W + 2;
    localparam int MOTO_BASE = csbp_pkg::WIN_W - csbp_pkg::BYTE_W + 1;

    logic [FB_W-1:0]   frame_nbits;
    logic [2:0]        s7;
    logic              flen_ok;
    logic              len_ok;
    logic              start_ok;
    logic              intel_ok;
    logic [TAIL_W-1:0] tail;
    logic [LAST_W-1:0] last_byte;
    logic              moto_ok;

    always_comb begin
        frame_nbits = {i_cfg.frame_length, 3'b000};
        s7          = i_cfg.sig_start[2:0];
        flen_ok     = (i_cfg.frame_length != '0) &&
                      (i_cfg.frame_length <= csbp_pkg::FLEN_W'(csbp_pkg::MAX_BYTES));
        len_ok      = (i_cfg.sig_len != '0);
        start_ok    = FB_W'(i_cfg.sig_start) < frame_nbits;
        intel_ok    = (FB_W'(i_cfg.sig_start) + FB_W'(i_cfg.sig_len)) <= frame_nbits;
        // The big-endian walk covers the rest of the first byte, then whole bytes upwards.
        tail        = TAIL_W'(i_cfg.sig_len) + TAIL_W'(csbp_pkg::BYTE_W - 2) - TAIL_W'(s7);
        last_byte   = LAST_W'(i_cfg.sig_start[csbp_pkg::START_W-1:3]) +
                      LAST_W'(tail[TAIL_W-1:3]);
        moto_ok     = last_byte < LAST_W'(i_cfg.frame_length);

        o_geom.fits       = flen_ok && len_ok && start_ok &&
                            (i_cfg.motorola ? moto_ok : intel_ok);
        o_geom.first_byte = i_cfg.sig_start[csbp_pkg::START_W-1:3];
        o_geom.shamt      = i_cfg.motorola ?
                            csbp_pkg::SHAMT_W'(MOTO_BASE) + csbp_pkg::SHAMT_W'(s7)
                                - csbp_pkg::SHAMT_W'(i_cfg.sig_len) :
                            csbp_pkg::SHAMT_W'(s7);
        o_geom.len_mask   = (csbp_pkg::RAW_W'(1) << i_cfg.sig_len) - csbp_pkg::RAW_W'(1);
    end

endmodule

@@ tb/sv/tb.sv @@
// Testbench of the CAN signal pack and unpack block: directed and random frame operations.
module tb;

    localparam int MAX_BYTES  = csbp_pkg::MAX_BYTES;
    localparam int RAW_W      = csbp_pkg::RAW_W;
    localparam int BYTE_W     = csbp_pkg::BYTE_W;
    localparam int IDX_W      = csbp_pkg::IDX_W;
    localparam int START_W    = csbp_pkg::START_W;
    localparam int LEN_W      = csbp_pkg::LEN_W;
    localparam int FLEN_W     = csbp_pkg::FLEN_W;
    localparam int CFG_IDX_W  = csbp_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = csbp_pkg::CFG_DATA_W;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RANDOM_PHASES = 23;
    localparam int LONG_LEN      = RAW_W - 1;
    localparam int CFG_SPARE_FIRST = csbp_pkg::CFG_FRAME_LENGTH + 1;

    typedef struct packed {
        logic              ok;
        logic [RAW_W-1:0]  raw_out;
        logic [BYTE_W-1:0] byte_out;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    csbp_in_if  in_ch ();
    csbp_out_if out_ch ();
    csbp_cfg_if cfg_ch ();

    can_signal_bit_pack_unpack uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    logic [BYTE_W-1:0]  frame_img [MAX_BYTES];
    csbp_pkg::t_sig_cfg sig_cfg;
    t_frame_result      pending_results [$];
    int unsigned        error_count = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_stall_pct = 0;
    bit                 long_hold = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic csbp_pkg::t_sig_cfg make_signal(input int unsigned start,
                                                       input int unsigned len,
                                                       input int unsigned moto,
                                                       input int unsigned sgn,
                                                       input int unsigned flen);
        csbp_pkg::t_sig_cfg c;
        c.sig_start    = START_W'(start);
        c.sig_len      = LEN_W'(len);
        c.motorola     = 1'(moto);
        c.sign_ext     = 1'(sgn);
        c.frame_length = FLEN_W'(flen);
        return c;
    endfunction

    function automatic int unsigned next_walk_bit(input int unsigned pos);
        return (pos % 8 == 0) ? pos + 15 : pos - 1;
    endfunction

    function automatic bit signal_fits(input csbp_pkg::t_sig_cfg c);
        int unsigned nbits;
        int unsigned pos;
        if (c.frame_length == 0 || c.frame_length > MAX_BYTES) return 1'b0;
        if (c.sig_len == 0) return 1'b0;
        nbits = c.frame_length * 8;
        if (c.sig_start >= nbits) return 1'b0;
        if (!c.motorola) return (c.sig_start + c.sig_len <= nbits);
        pos = c.sig_start;
        for (int i = 0; i < c.sig_len; i++) begin
            if (pos >= nbits) return 1'b0;
            pos = next_walk_bit(pos);
        end
        return 1'b1;
    endfunction

    function automatic logic [RAW_W-1:0] extract_signal(input csbp_pkg::t_sig_cfg c);
        logic [RAW_W-1:0] raw;
        int unsigned      pos;
        logic             b;
        raw = '0;
        pos = c.sig_start;
        for (int i = 0; i < c.sig_len; i++) begin
            b = frame_img[pos >> 3][pos & 7];
            if (c.motorola) begin
                raw = {raw[RAW_W-2:0], b};
                pos = next_walk_bit(pos);
            end else begin
                raw[i] = b;
                pos++;
            end
        end
        if (c.sign_ext && c.sig_len < LONG_LEN && raw[c.sig_len - 1])
            raw |= ~((RAW_W'(1) << c.sig_len) - RAW_W'(1));
        return raw;
    endfunction

    function automatic void insert_signal(input csbp_pkg::t_sig_cfg c,
                                          input logic [RAW_W-1:0] value);
        int unsigned pos;
        pos = c.sig_start;
        for (int i = 0; i < c.sig_len; i++) begin
            if (c.motorola) begin
                frame_img[pos >> 3][pos & 7] = value[c.sig_len - 1 - i];
                pos = next_walk_bit(pos);
            end else begin
                frame_img[pos >> 3][pos & 7] = value[i];
                pos++;
            end
        end
    endfunction

    function automatic t_frame_result apply_frame_op(input csbp_pkg::t_op op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [BYTE_W-1:0] val,
                                                     input logic [RAW_W-1:0] raw);
        t_frame_result res;
        res = '0;
        case (op)
            csbp_pkg::OP_LOAD: begin
                if (idx < MAX_BYTES) begin
                    frame_img[idx] = val;
                    res.ok = 1'b1;
                end
            end
            csbp_pkg::OP_READ: begin
                if (idx < MAX_BYTES) begin
                    res.byte_out = frame_img[idx];
                    res.ok = 1'b1;
                end
            end
            csbp_pkg::OP_EXTRACT: begin
                if (signal_fits(sig_cfg)) begin
                    res.raw_out = extract_signal(sig_cfg);
                    res.ok = 1'b1;
                end
            end
            default: begin
                if (signal_fits(sig_cfg)) begin
                    insert_signal(sig_cfg, raw);
                    res.ok = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            csbp_pkg::CFG_SIG_START:    sig_cfg.sig_start = data[START_W-1:0];
            csbp_pkg::CFG_SIG_LEN:      sig_cfg.sig_len = data[LEN_W-1:0];
            csbp_pkg::CFG_MOTOROLA:     sig_cfg.motorola = data[0];
            csbp_pkg::CFG_SIGN_EXT:     sig_cfg.sign_ext = data[0];
            csbp_pkg::CFG_FRAME_LENGTH: sig_cfg.frame_length = data[FLEN_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] random_raw();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return {1'b1, {(RAW_W-1){1'b0}}};
            3: return {1'b0, {(RAW_W-1){1'b1}}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic csbp_pkg::t_sig_cfg random_signal();
        csbp_pkg::t_sig_cfg c;
        int unsigned        r;
        c.motorola = 1'($urandom);
        c.sign_ext = 1'($urandom);
        r = $urandom_range(99);
        if (r < 5) c.frame_length = '0;
        else if (r < 10)
            c.frame_length = FLEN_W'($urandom_range((1 << FLEN_W) - 1, MAX_BYTES + 1));
        else if (r < 30) c.frame_length = FLEN_W'(MAX_BYTES);
        else if (r < 45) c.frame_length = FLEN_W'(8);
        else c.frame_length = FLEN_W'($urandom_range(MAX_BYTES, 1));
        r = $urandom_range(99);
        if (r < 10) c.sig_len = LEN_W'(LONG_LEN);
        else if (r < 20) c.sig_len = LEN_W'(1);
        else if (r < 25) c.sig_len = '0;
        else c.sig_len = LEN_W'($urandom_range(LONG_LEN - 1, 2));
        c.sig_start = START_W'($urandom);
        if ($urandom_range(99) >= 15 && c.frame_length != 0 && c.frame_length <= MAX_BYTES) begin
            for (int k = 0; k < 64 && !signal_fits(c); k++) begin
                c.sig_start = START_W'($urandom_range(c.frame_length * 8 - 1));
            end
        end
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        apply_register(idx, data);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic program_signal(input csbp_pkg::t_sig_cfg c);
        logic [CFG_DATA_W-1:0] noise;
        wait_idle();
        noise = CFG_DATA_W'($urandom);
        write_reg(csbp_pkg::CFG_SIG_START, {noise[CFG_DATA_W-1:START_W], c.sig_start});
        noise = CFG_DATA_W'($urandom);
        write_reg(csbp_pkg::CFG_SIG_LEN, {noise[CFG_DATA_W-1:LEN_W], c.sig_len});
        noise = CFG_DATA_W'($urandom);
        write_reg(csbp_pkg::CFG_MOTOROLA, {noise[CFG_DATA_W-1:1], c.motorola});
        noise = CFG_DATA_W'($urandom);
        write_reg(csbp_pkg::CFG_SIGN_EXT, {noise[CFG_DATA_W-1:1], c.sign_ext});
        noise = CFG_DATA_W'($urandom);
        write_reg(csbp_pkg::CFG_FRAME_LENGTH, {noise[CFG_DATA_W-1:FLEN_W], c.frame_length});
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_item(input csbp_pkg::t_op op, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic [RAW_W-1:0] raw);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid      <= 1'b1;
        in_ch.op         <= op;
        in_ch.byte_index <= idx;
        in_ch.byte_value <= val;
        in_ch.raw_in     <= raw;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_results.push_back(apply_frame_op(op, idx, val, raw));
    endtask

    task automatic send_op(input csbp_pkg::t_op op, input logic [RAW_W-1:0] raw);
        send_item(op, IDX_W'($urandom), BYTE_W'($urandom), raw);
    endtask

    task automatic send_random_item();
        int unsigned   r;
        csbp_pkg::t_op op;
        r = $urandom_range(99);
        if (r < 25) op = csbp_pkg::OP_LOAD;
        else if (r < 45) op = csbp_pkg::OP_READ;
        else if (r < 75) op = csbp_pkg::OP_EXTRACT;
        else op = csbp_pkg::OP_INSERT;
        send_item(op, IDX_W'($urandom), BYTE_W'($urandom), random_raw());
    endtask

    task automatic test_default_signal();
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        send_op(csbp_pkg::OP_INSERT, '1);
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
    endtask

    task automatic test_byte_access();
        send_item(csbp_pkg::OP_LOAD, '0, 8'hFF, random_raw());
        send_item(csbp_pkg::OP_LOAD, '1, 8'hA5, random_raw());
        send_item(csbp_pkg::OP_LOAD, IDX_W'(31), 8'h5A, random_raw());
        send_item(csbp_pkg::OP_READ, '0, BYTE_W'($urandom), random_raw());
        send_item(csbp_pkg::OP_READ, '1, BYTE_W'($urandom), random_raw());
        send_item(csbp_pkg::OP_READ, IDX_W'(31), BYTE_W'($urandom), random_raw());
    endtask

    task automatic test_signal_extremes();
        program_signal(make_signal(0, LONG_LEN, 0, 1, 8));
        send_op(csbp_pkg::OP_INSERT, {1'b1, {(RAW_W-2){1'b0}}, 1'b1});
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        program_signal(make_signal(7, LONG_LEN, 1, 1, 8));
        send_op(csbp_pkg::OP_INSERT, '1);
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        program_signal(make_signal(511, 1, 0, 1, MAX_BYTES));
        send_op(csbp_pkg::OP_INSERT, '1);
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        program_signal(make_signal(511, 8, 1, 1, MAX_BYTES));
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
    endtask

    task automatic test_invalid_signal();
        program_signal(make_signal(0, 8, 0, 0, 0));
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        program_signal(make_signal(0, 8, 0, 0, MAX_BYTES + 1));
        send_op(csbp_pkg::OP_INSERT, '1);
        program_signal(make_signal(0, 8, 1, 1, (1 << FLEN_W) - 1));
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        program_signal(make_signal(0, 0, 0, 0, 8));
        send_op(csbp_pkg::OP_INSERT, '1);
        program_signal(make_signal(64, 1, 0, 0, 8));
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
        program_signal(make_signal(60, 8, 0, 0, 8));
        send_op(csbp_pkg::OP_INSERT, '1);
        program_signal(make_signal(56, 2, 1, 0, 8));
        send_op(csbp_pkg::OP_INSERT, '1);
    endtask

    task automatic test_unused_register();
        program_signal(make_signal(12, 20, 0, 1, 16));
        for (int k = CFG_SPARE_FIRST; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_ch.valid <= 1'b0;
        send_op(csbp_pkg::OP_EXTRACT, random_raw());
    endtask

    task automatic test_backpressure();
        program_signal(make_signal(20, 30, 0, 1, 12));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold      = 1'b1;
        repeat (12) send_random_item();
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_signal(random_signal());
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 58;
                end
                default: begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            repeat ($urandom_range(50, 30)) send_random_item();
        end
    endtask

    initial begin : result_sink
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_frame_result want;
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no expected result pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, out_ch.ok);
                    error_count++;
                end
                if (out_ch.raw_out !== want.raw_out) begin
                    $error("raw_out: expected %h, got %h", want.raw_out, out_ch.raw_out);
                    error_count++;
                end
                if (out_ch.byte_out !== want.byte_out) begin
                    $error("byte_out: expected %h, got %h", want.byte_out, out_ch.byte_out);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.op         = csbp_pkg::OP_LOAD;
        in_ch.byte_index = '0;
        in_ch.byte_value = '0;
        in_ch.raw_in     = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = csbp_pkg::CFG_SIG_START;
        cfg_ch.data      = '0;
        foreach (frame_img[k]) frame_img[k] = '0;
        sig_cfg = make_signal(0, 8, 0, 0, 8);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_signal();
        test_byte_access();
        test_signal_extremes();
        test_invalid_signal();
        test_unused_register();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
